// ===== rtl/aha_pkg.sv =====
// Shared types and constants for the arena heap allocator.
// No dependencies; imported by aha_ctrl, the top level and the checker.
package aha_pkg;

   localparam int ARENA_WORDS = 1024;
   localparam int ADDR_W      = $clog2(ARENA_WORDS);
   localparam int HDR_W       = ADDR_W + 2;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_WALK,
      ST_CARVE,
      ST_CARVE_TOP,
      ST_FREE_NXT
   } state_type;

   typedef struct packed {
      logic                     rd_en;
      logic [ADDR_W-1:0]        rd_addr;
      logic                     wr_en;
      logic [ADDR_W-1:0]        wr_addr;
      logic signed [HDR_W-1:0]  wr_data;
   } mem_req_type;

endpackage

// ===== rtl/aha_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module aha_ram #(
   parameter int  WIDTH = 12,
   parameter int  DEPTH = 1024,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/aha_ctrl.sv =====
// Allocator sequencer: walks the header chain one RAM read per cycle,
// then writes back. Depends on aha_pkg.
module aha_ctrl
   import aha_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_type,
   input  logic [ADDR_W-1:0]       req_size,
   input  logic [ADDR_W-1:0]       req_addr,
   output logic                    rsp_valid,
   output logic                    rsp_ok,
   output logic [ADDR_W-1:0]       rsp_block_addr,
   output mem_req_type             mem_req,
   input  logic [HDR_W-1:0]        mem_rd_data
);

   localparam int NW = HDR_W + 1;
   localparam logic signed [HDR_W-1:0] HDR_ONE  = 1;
   localparam logic signed [HDR_W-1:0] HDR_ZERO = 0;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [ADDR_W-1:0]       size_ff, size_in;
   logic [ADDR_W-1:0]       q_ff, q_in;
   logic [ADDR_W-1:0]       p_ff, p_in;
   logic [ADDR_W-1:0]       pr_ff, pr_in;
   logic signed [HDR_W-1:0] pred_hdr_ff, pred_hdr_in;
   logic                    has_pred_ff, has_pred_in;
   logic [ADDR_W-1:0]       base_ff, base_in;
   logic signed [HDR_W-1:0] merged_ff, merged_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [ADDR_W-1:0]       rsp_addr_ff, rsp_addr_in;

   // datapath terms on the header word returned by the RAM
   logic signed [HDR_W-1:0] hdr;
   logic [HDR_W-1:0]        hdr_abs;
   logic [NW-1:0]           np;
   logic                    np_end;
   logic signed [HDR_W-1:0] size_hdr;
   logic signed [HDR_W-1:0] neg_size;
   logic                    exact;
   logic signed [NW-1:0]    need_w;
   logic signed [NW-1:0]    hdr_ext;
   logic                    room_fail;
   logic signed [HDR_W-1:0] first_new;
   logic [ADDR_W-1:0]       top;
   logic signed [HDR_W-1:0] len;
   logic                    pred_pos;
   logic signed [HDR_W-1:0] merged;
   logic [ADDR_W-1:0]       base;
   logic [NW-1:0]           nxt;
   logic                    nxt_in;
   logic                    succ_pos;
   logic signed [HDR_W-1:0] succ_sum;
   logic                    accept;
   logic                    early_fail;
   logic                    at_target;

   assign hdr       = $signed(mem_rd_data);
   assign hdr_abs   = hdr[HDR_W-1] ? (~hdr + HDR_W'(1)) : hdr;
   assign np        = NW'(p_ff) + NW'(hdr_abs) + NW'(1);
   assign np_end    = (np >= NW'(ARENA_WORDS));
   assign size_hdr  = $signed(HDR_W'(size_ff));
   assign neg_size  = -size_hdr;
   assign exact     = !hdr[HDR_W-1] && (hdr == size_hdr);
   assign need_w    = $signed(NW'(size_ff)) + $signed(NW'(1));
   assign hdr_ext   = NW'(hdr);
   assign room_fail = (need_w > hdr_ext);
   assign first_new = hdr - size_hdr - HDR_ONE;
   assign top       = first_new[ADDR_W-1:0] + ADDR_W'(1);
   assign len       = -hdr;
   assign pred_pos  = has_pred_ff && (pred_hdr_ff > HDR_ZERO);
   assign merged    = pred_pos ? (pred_hdr_ff + len + HDR_ONE) : len;
   assign base      = pred_pos ? pr_ff : q_ff;
   assign nxt       = NW'(base) + NW'($unsigned(merged)) + NW'(1);
   assign nxt_in    = (nxt < NW'(ARENA_WORDS));
   assign succ_pos  = (hdr > HDR_ZERO);
   assign succ_sum  = merged_ff + hdr + HDR_ONE;
   assign at_target = (p_ff == q_ff);

   assign accept     = start && (state_ff == ST_IDLE);
   assign early_fail = (req_type == OP_ALLOC) ? (req_size == '0) : (req_addr == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && !early_fail) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (op_ff == OP_ALLOC) begin
               if (exact) begin
                  state_in = ST_IDLE;
               end else if (np_end) begin
                  state_in = ST_CARVE;
               end
            end else if (at_target) begin
               if (hdr[HDR_W-1] && nxt_in) begin
                  state_in = ST_FREE_NXT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (np_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_CARVE: begin
            state_in = room_fail ? ST_IDLE : ST_CARVE_TOP;
         end
         ST_CARVE_TOP: begin
            state_in = ST_IDLE;
         end
         ST_FREE_NXT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and RAM port
   always_comb begin
      op_in        = op_ff;
      size_in      = size_ff;
      q_in         = q_ff;
      p_in         = p_ff;
      pr_in        = pr_ff;
      pred_hdr_in  = pred_hdr_ff;
      has_pred_in  = has_pred_ff;
      base_in      = base_ff;
      merged_in    = merged_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = rsp_ok_ff;
      rsp_addr_in  = rsp_addr_ff;
      mem_req      = '0;
      unique case (state_ff)
         ST_INIT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = '0;
            mem_req.wr_data = HDR_W'(ARENA_WORDS - 1);
         end
         ST_IDLE: begin
            if (accept) begin
               op_in       = op_type'(req_type);
               size_in     = req_size;
               q_in        = req_addr - ADDR_W'(1);
               p_in        = '0;
               has_pred_in = 1'b0;
               if (early_fail) begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b0;
                  rsp_addr_in  = '0;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = '0;
               end
            end
         end
         ST_WALK: begin
            if (op_ff == OP_ALLOC) begin
               if (exact) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = p_ff;
                  mem_req.wr_data = neg_size;
                  rsp_valid_in    = 1'b1;
                  rsp_ok_in       = 1'b1;
                  rsp_addr_in     = p_ff + ADDR_W'(1);
               end else if (np_end) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = '0;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = np[ADDR_W-1:0];
                  p_in            = np[ADDR_W-1:0];
               end
            end else if (at_target) begin
               if (!hdr[HDR_W-1]) begin
                  // block already free
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b0;
                  rsp_addr_in  = '0;
               end else if (nxt_in) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = nxt[ADDR_W-1:0];
                  base_in         = base;
                  merged_in       = merged;
               end else begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = base;
                  mem_req.wr_data = merged;
                  rsp_valid_in    = 1'b1;
                  rsp_ok_in       = 1'b1;
                  rsp_addr_in     = '0;
               end
            end else begin
               pr_in       = p_ff;
               pred_hdr_in = hdr;
               has_pred_in = 1'b1;
               if (np_end) begin
                  // header not on the chain
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b0;
                  rsp_addr_in  = '0;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = np[ADDR_W-1:0];
                  p_in            = np[ADDR_W-1:0];
               end
            end
         end
         ST_CARVE: begin
            if (room_fail) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_addr_in  = '0;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = '0;
               mem_req.wr_data = first_new;
               base_in         = top;
            end
         end
         ST_CARVE_TOP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = base_ff;
            mem_req.wr_data = neg_size;
            rsp_valid_in    = 1'b1;
            rsp_ok_in       = 1'b1;
            rsp_addr_in     = base_ff + ADDR_W'(1);
         end
         ST_FREE_NXT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = base_ff;
            mem_req.wr_data = succ_pos ? succ_sum : merged_ff;
            rsp_valid_in    = 1'b1;
            rsp_ok_in       = 1'b1;
            rsp_addr_in     = '0;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      size_ff     <= size_in;
      q_ff        <= q_in;
      p_ff        <= p_in;
      pr_ff       <= pr_in;
      pred_hdr_ff <= pred_hdr_in;
      has_pred_ff <= has_pred_in;
      base_ff     <= base_in;
      merged_ff   <= merged_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_block_addr = rsp_addr_ff;

endmodule

// ===== rtl/arena_heap_allocator_top.sv =====
// Top level of the arena heap allocator: header RAM plus sequencer.
// Depends on aha_pkg, aha_ram and aha_ctrl.
//
// Usage:
//  - Request channel: a transaction is taken at a rising edge with start high
//    and busy low. req_type selects allocate (req_size words) or free
//    (block at payload offset req_addr).
//  - Response channel: exactly one response per request, shown for one
//    cycle with rsp_valid high. rsp_ok reports success, rsp_block_addr
//    carries the payload offset of a granted block, else 0. The receiver
//    cannot stall; the response is taken in the cycle it is shown.
//  - Walk: the sequencer reads one header per cycle from the RAM, along
//    the chain until the block is found, then writes back. An allocate
//    that misses walks the whole chain and then carves from block 0.
//    Zero-size allocates and frees of offset 0 respond the cycle after
//    acceptance.
//  - busy drops in the cycle the response is shown, so the next request
//    can be accepted then; one request is in flight at a time, so no RAM
//    forwarding is needed.
//  - Reset: synchronous. After reset an init state writes the first
//    header (whole arena free); busy is high during it.
module arena_heap_allocator_top
   import aha_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_type,
   input  logic [ADDR_W-1:0] req_size,
   input  logic [ADDR_W-1:0] req_addr,
   output logic              rsp_valid,
   output logic              rsp_ok,
   output logic [ADDR_W-1:0] rsp_block_addr
);

   mem_req_type       mem_req;
   logic [HDR_W-1:0]  mem_rd_data;

   // chain walk and write-back sequencer
   aha_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_size       (req_size),
      .req_addr       (req_addr),
      .rsp_valid      (rsp_valid),
      .rsp_ok         (rsp_ok),
      .rsp_block_addr (rsp_block_addr),
      .mem_req        (mem_req),
      .mem_rd_data    (mem_rd_data)
   );

   // header store, one word per arena word; only chain headers are read
   aha_ram #(
      .WIDTH (HDR_W),
      .DEPTH (ARENA_WORDS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ===== rtl/aha_checker.sv =====
// Port-level checks for the arena heap allocator, bound to the top level.
// Depends on aha_pkg.
module aha_checker
   import aha_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              req_type,
   input logic [ADDR_W-1:0] req_size,
   input logic [ADDR_W-1:0] req_addr,
   input logic              rsp_valid,
   input logic              rsp_ok,
   input logic [ADDR_W-1:0] rsp_block_addr
);

   // init cycle follows reset
   a_init_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   // a response ends the transaction
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // failed responses carry no offset
   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_block_addr == '0))
      else $error("offset on failed response");

   // zero-size allocate is refused at once
   a_zero_size: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == OP_ALLOC) && (req_size == '0))
         |=> (rsp_valid && !rsp_ok))
      else $error("zero-size allocate not refused");

   // free of offset 0 is refused at once
   a_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == OP_FREE) && (req_addr == '0))
         |=> (rsp_valid && !rsp_ok))
      else $error("free of offset 0 not refused");

endmodule

bind arena_heap_allocator_top aha_checker u_aha_checker (.*);

// ===== test/arena_heap_allocator_top_tb.sv =====
// Self-checking testbench for arena_heap_allocator_top: allocate and free
// transactions against a header-level model of the heap, one field per port.
// Depends on aha_pkg and the arena_heap_allocator_top RTL.
`timescale 1ns / 100ps

module arena_heap_allocator_top_tb;
   import aha_pkg::*;

   localparam int N_RANDOM       = 920;
   localparam int WATCHDOG_LIMIT = 5000;   // longest walk is ~520 headers

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] size;
      logic [ADDR_W-1:0] addr;
   } heap_req_type;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] block_addr;
   } grant_type;

   logic              clock;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   logic              req_type = 1'b0;
   logic [ADDR_W-1:0] req_size = '0;
   logic [ADDR_W-1:0] req_addr = '0;
   logic              busy;
   logic              rsp_valid;
   logic              rsp_ok;
   logic [ADDR_W-1:0] rsp_block_addr;

   arena_heap_allocator_top DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_size       (req_size),
      .req_addr       (req_addr),
      .rsp_valid      (rsp_valid),
      .rsp_ok         (rsp_ok),
      .rsp_block_addr (rsp_block_addr)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Heap model: one signed header per word, same width as the RAM.
   // Positive or zero = free, negative = busy; span = |len| + 1.
   // ---------------------------------------------------------------------
   logic signed [HDR_W-1:0] heap_hdr [ARENA_WORDS];

   heap_req_type pending_q [$];   // transactions waiting for the driver
   grant_type    grant_q   [$];   // expected responses, oldest first
   int           busy_blocks [$]; // payload offsets of busy blocks on the chain
   int           free_blocks [$]; // payload offsets of free blocks on the chain

   int n_pushed   = 0;
   int n_accepted = 0;
   int n_fail     = 0;

   function automatic int hdr_span(input int h);
      return (h < 0) ? 1 - h : h + 1;
   endfunction

   // Exact fit first; on a miss, carve from the top of block 0.
   // The room check is signed, so a busy block 0 never carves.
   function automatic void heap_alloc(input int sz, output logic ok, output int granted);
      int p;
      int h;
      int first;
      int top;
      ok      = 1'b0;
      granted = 0;
      if (sz == 0) return;
      p = 0;
      while (p < ARENA_WORDS) begin
         h = int'(heap_hdr[p]);
         if (h >= 0 && h == sz) begin
            heap_hdr[p] = HDR_W'(-sz);
            ok          = 1'b1;
            granted     = p + 1;
            return;
         end
         p += hdr_span(h);
      end
      first = int'(heap_hdr[0]);
      if (sz + 1 > first) return;
      first -= sz + 1;
      heap_hdr[0] = HDR_W'(first);
      top = first + 1;
      if (top >= ARENA_WORDS) return;
      heap_hdr[top] = HDR_W'(-sz);
      ok            = 1'b1;
      granted       = top + 1;
   endfunction

   // Walk to the predecessor, release, then merge pred (if > 0) and
   // successor (if > 0). Block 0 has no predecessor.
   function automatic logic heap_free(input int addr);
      int q;
      int p;
      int pr;
      int nxt;
      int len;
      bit has_pred;
      if (addr == 0) return 1'b0;
      q        = addr - 1;
      p        = 0;
      pr       = 0;
      has_pred = 1'b0;
      while (p < ARENA_WORDS && p != q) begin
         pr       = p;
         has_pred = 1'b1;
         p       += hdr_span(int'(heap_hdr[p]));
      end
      if (p != q) return 1'b0;
      if (heap_hdr[q] >= 0) return 1'b0;
      len         = -int'(heap_hdr[q]);
      heap_hdr[q] = HDR_W'(len);
      if (has_pred && heap_hdr[pr] > 0) begin
         heap_hdr[pr] = HDR_W'(int'(heap_hdr[pr]) + len + 1);
         p            = pr;
      end
      nxt = p + int'(heap_hdr[p]) + 1;
      if (nxt < ARENA_WORDS && heap_hdr[nxt] > 0)
         heap_hdr[p] = HDR_W'(int'(heap_hdr[p]) + int'(heap_hdr[nxt]) + 1);
      return 1'b1;
   endfunction

   // One response per transaction; free never returns an address.
   function automatic void predict_grant(input op_type op, input int sz, input int addr);
      grant_type g;
      int        granted;
      logic      ok;
      if (op == OP_ALLOC) begin
         heap_alloc(sz, ok, granted);
         if (!ok) granted = 0;
      end else begin
         ok      = heap_free(addr);
         granted = 0;
      end
      g.ok         = ok;
      g.block_addr = granted[ADDR_W-1:0];
      grant_q.push_back(g);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: bursts of random length separated by random gaps. The gap
   // counter runs from the accept edge, so gaps land anywhere in the walk.
   // ---------------------------------------------------------------------
   int           burst_left = 1;
   int           gap_left   = 0;
   heap_req_type drv_item;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_grant(op_type'(req_type), int'(req_size), int'(req_addr));
            n_accepted++;
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_q.size() > 0) begin
               drv_item = pending_q.pop_front();
               start    <= 1'b1;
               req_type <= drv_item.op;
               req_size <= drv_item.size;
               req_addr <= drv_item.addr;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
               end else begin
                  burst_left--;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: a response is taken at the edge that ends its cycle.
   // ---------------------------------------------------------------------
   grant_type mon_exp;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (grant_q.size() == 0) begin
            $error("response with no transaction pending: ok=%0d block_addr=%0d",
                   rsp_ok, rsp_block_addr);
            n_fail++;
         end else begin
            mon_exp = grant_q.pop_front();
            if (rsp_ok !== mon_exp.ok) begin
               $error("rsp_ok: expected %0d, actual %0d", mon_exp.ok, rsp_ok);
               n_fail++;
            end
            if (rsp_block_addr !== mon_exp.block_addr) begin
               $error("rsp_block_addr: expected %0d, actual %0d",
                      mon_exp.block_addr, rsp_block_addr);
               n_fail++;
            end
         end
      end
   end

   // Watchdog: any accepted request or response restarts the count.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus. Each transaction is chosen only once the previous one has
   // been accepted, so the choice can look at the current heap layout
   // (live blocks for frees, free lengths for exact fits). Checked at the
   // falling edge to stay clear of the driver.
   // ---------------------------------------------------------------------
   task automatic sync_model(input bit drain);
      while (n_accepted != n_pushed || (drain && grant_q.size() != 0))
         @(negedge clock);
   endtask

   task automatic issue(input op_type op, input int sz, input int addr);
      heap_req_type it;
      sync_model(1'b0);
      it.op   = op;
      it.size = sz[ADDR_W-1:0];
      it.addr = addr[ADDR_W-1:0];
      pending_q.push_back(it);
      n_pushed++;
   endtask

   function automatic void scan_heap();
      int p;
      int h;
      busy_blocks.delete();
      free_blocks.delete();
      p = 0;
      while (p < ARENA_WORDS) begin
         h = int'(heap_hdr[p]);
         if (h < 0) busy_blocks.push_back(p + 1);
         else       free_blocks.push_back(p + 1);
         p += hdr_span(h);
      end
   endfunction

   // A carve leaving block 0 at zero length would pin it there for good
   // (zero-length blocks never merge), so the random part steers around it.
   function automatic int safe_size(input int sz);
      return (sz + 1 == int'(heap_hdr[0])) ? sz + 1 : sz;
   endfunction

   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40 && free_blocks.size() > 0)
         return int'(heap_hdr[free_blocks[$urandom_range(0, free_blocks.size() - 1)] - 1]);
      if (r < 80) return $urandom_range(1, 12);
      if (r < 95) return $urandom_range(13, 200);
      return $urandom_range(201, 1023);
   endfunction

   function automatic int pick_free_addr();
      int r;
      r = $urandom_range(0, 99);
      if (busy_blocks.size() > 0 && r < 85)
         return busy_blocks[$urandom_range(0, busy_blocks.size() - 1)];
      // inside a busy block: usually off the chain
      if (busy_blocks.size() > 0 && r < 92)
         return (busy_blocks[$urandom_range(0, busy_blocks.size() - 1)]
                 + $urandom_range(1, 3)) % ARENA_WORDS;
      // already free
      if (free_blocks.size() > 0)
         return free_blocks[$urandom_range(0, free_blocks.size() - 1)];
      return $urandom_range(0, ARENA_WORDS - 1);
   endfunction

   initial begin
      int i;
      int roll;
      int free_pct;
      int nb;

      for (i = 0; i < ARENA_WORDS; i++) heap_hdr[i] = '0;
      heap_hdr[0] = HDR_W'(ARENA_WORDS - 1);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // --- directed, from the reset layout (one free block of 1023) ---
      issue(OP_ALLOC, 0, $urandom);                  // zero size refused
      issue(OP_FREE, $urandom, 0);                   // offset 0 never on chain
      issue(OP_FREE, $urandom, 1023);                // not a header
      issue(OP_ALLOC, 1023, $urandom);               // exact fit of block 0 -> 1
      issue(OP_ALLOC, 1, $urandom);                  // block 0 busy: signed room check
      issue(OP_FREE, $urandom, 1);                   // first block, no predecessor
      issue(OP_FREE, $urandom, 1);                   // already free
      issue(OP_ALLOC, 4, $urandom);                  // carve -> 1020
      issue(OP_ALLOC, 4, $urandom);                  // carve -> 1015
      issue(OP_FREE, $urandom, 1020);                // busy predecessor, no merge
      issue(OP_ALLOC, 4, $urandom);                  // exact fit of the hole -> 1020
      issue(OP_FREE, $urandom, 1016);                // inside a block
      issue(OP_FREE, $urandom, 1015);                // merges into free block 0
      issue(OP_FREE, $urandom, 1020);                // merges again: back to one block

      // --- random, with occasional fill bursts and full drains ---
      for (i = 0; i < N_RANDOM; i++) begin
         sync_model(i % 200 == 199);
         scan_heap();
         nb       = busy_blocks.size();
         roll     = $urandom_range(0, 99);
         free_pct = (nb > 40) ? 70 : (nb < 4) ? 15 : 45;
         if ((i % 300) >= 270) begin
            issue(OP_ALLOC, safe_size($urandom_range(16, 64)), $urandom);
         end else if (roll < 8) begin
            if ($urandom_range(0, 1) == 0)
               issue(OP_ALLOC, safe_size($urandom_range(0, 1023)), $urandom);
            else
               issue(OP_FREE, $urandom, $urandom_range(0, 1023));
         end else if (roll < 8 + free_pct) begin
            issue(OP_FREE, $urandom, pick_free_addr());
         end else begin
            issue(OP_ALLOC, safe_size(pick_size()), $urandom);
         end
      end

      // --- release everything; the heap folds back into one block ---
      forever begin
         sync_model(1'b0);
         scan_heap();
         if (busy_blocks.size() == 0) break;
         issue(OP_FREE, $urandom, busy_blocks[$urandom_range(0, busy_blocks.size() - 1)]);
      end
      sync_model(1'b1);

      // --- zero-length block 0: left for last, it ends all carving ---
      issue(OP_ALLOC, int'(heap_hdr[0]) - 1, $urandom);  // block 0 drops to 0, grant 2
      issue(OP_ALLOC, 1, $urandom);                  // no room left
      issue(OP_FREE, $urandom, 2);                   // zero-length pred is not absorbed
      issue(OP_ALLOC, 1022, $urandom);               // exact fit behind block 0
      issue(OP_FREE, $urandom, 1);                   // block 0 free at length 0
      issue(OP_FREE, $urandom, 2);

      sync_model(1'b1);
      repeat (40) @(posedge clock);
      if (n_fail == 0 && grant_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
